### design/fpalu_pkg.sv
// fixed-point alu package: operation codes and default sizes
// no dependencies
package fpalu_pkg;

  localparam int FRAC_BITS_DEF  = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH    = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_EQ       = 4'd6,
    OP_GE       = 4'd7,
    OP_LE       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } alu_op_t;

endpackage

### design/fixed_point_alu_unit.sv
// fixed-point alu top level: add/sub/mul/div/compare/min/max/inc/dec/convert on signed raw operands
// depends on fpalu_pkg
//
//  channel | dir | tdata                          | tuser
//  in_     | in  | operand_a[31:0], operand_b     | operation[3:0]
//  out_    | out | result_value[31:0]             | compare_true, divide_by_zero
//
// every beat goes through DATA_WIDTH+FRAC_BITS+3 register stages (43 at defaults);
// the restoring divider, one quotient bit per stage, sets that depth
// a new beat is taken every cycle while the output is free or being taken
// a stall on out_tready freezes the whole pipeline, nothing is lost or repeated
// synchronous active-low reset clears the valid bits only
module fixed_point_alu_unit #(
  parameter int FRAC_BITS  = fpalu_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = fpalu_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic [3:0]  in_tuser,   // operation[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_value[31:0]
  output logic [1:0]  out_tuser   // compare_true[0], divide_by_zero[1]
);
  import fpalu_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int NW = DATA_WIDTH + FRAC_BITS;

  typedef struct packed {
    logic          valid;
    alu_op_t       op;
    logic [DW-1:0] res;
    logic          cmp;
    logic          dz;
    logic          neg;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    logic [DW-1:0] rem;
    logic [DW-1:0] quo;
  } stage_t;

  logic                       en;
  logic                       s0_valid_r;
  alu_op_t                    s0_op_r;
  logic signed [DW-1:0]       s0_a_r, s0_b_r;
  stage_t                     pipe_r [0:NW];
  stage_t                     pipe_nxt [0:NW];
  logic signed [2*DW-1:0]     prod_r;
  logic signed [2*DW-1:0]     prod_sh;
  logic                       out_valid_r;
  logic [31:0]                out_data_r;
  logic [1:0]                 out_user_r;
  logic [DW-1:0]              q_fin;
  logic [DW-1:0]              r_fin;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign prod_sh = prod_r >>> FRAC_BITS;

  // stage 1: everything but the divide iterations, then the divider stages,
  // one restoring step each; the first divider stage also finishes multiply
  always_comb begin
    logic [DW-1:0] mag_a, mag_b;
    logic          lt, gt;
    pipe_nxt[0] = '0;
    lt    = s0_a_r < s0_b_r;
    gt    = s0_b_r < s0_a_r;
    mag_a = s0_a_r[DW-1] ? DW'(-s0_a_r) : DW'(s0_a_r);
    mag_b = s0_b_r[DW-1] ? DW'(-s0_b_r) : DW'(s0_b_r);
    pipe_nxt[0].valid = s0_valid_r;
    pipe_nxt[0].op    = s0_op_r;
    pipe_nxt[0].neg   = s0_a_r[DW-1] ^ s0_b_r[DW-1];
    pipe_nxt[0].num   = NW'(mag_a) << FRAC_BITS;
    pipe_nxt[0].den   = mag_b;
    case (s0_op_r)
      OP_ADD:      pipe_nxt[0].res = DW'(s0_a_r + s0_b_r);
      OP_SUB:      pipe_nxt[0].res = DW'(s0_a_r - s0_b_r);
      OP_DIV:      pipe_nxt[0].dz  = (s0_b_r == '0);
      OP_GT:       pipe_nxt[0].cmp = gt;
      OP_LT:       pipe_nxt[0].cmp = lt;
      OP_EQ:       pipe_nxt[0].cmp = (s0_a_r == s0_b_r);
      OP_GE:       pipe_nxt[0].cmp = !lt;
      OP_LE:       pipe_nxt[0].cmp = !gt;
      OP_NE:       pipe_nxt[0].cmp = (s0_a_r != s0_b_r);
      OP_MIN:      pipe_nxt[0].res = lt ? s0_a_r : s0_b_r;
      OP_MAX:      pipe_nxt[0].res = gt ? s0_a_r : s0_b_r;
      OP_INC:      pipe_nxt[0].res = DW'(s0_a_r + DW'(1));
      OP_DEC:      pipe_nxt[0].res = DW'(s0_a_r - DW'(1));
      OP_FROM_INT: pipe_nxt[0].res = s0_a_r << FRAC_BITS;
      OP_TO_INT:   pipe_nxt[0].res = s0_a_r >>> FRAC_BITS;
      default:     pipe_nxt[0].res = '0;
    endcase

    for (int j = 0; j < NW; j++) begin
      logic [DW:0] trial;
      logic        ge;
      trial = {pipe_r[j].rem, pipe_r[j].num[NW-1]};
      ge    = trial >= {1'b0, pipe_r[j].den};
      pipe_nxt[j+1]     = pipe_r[j];
      pipe_nxt[j+1].rem = ge ? DW'(trial - {1'b0, pipe_r[j].den}) : DW'(trial);
      pipe_nxt[j+1].num = pipe_r[j].num << 1;
      pipe_nxt[j+1].quo = {pipe_r[j].quo[DW-2:0], ge};
      if (j == 0 && pipe_r[j].op == OP_MUL) begin
        pipe_nxt[j+1].res = prod_sh[DW-1:0];
      end
    end
  end

  assign q_fin = pipe_r[NW].neg ? DW'(-pipe_r[NW].quo) : pipe_r[NW].quo;

  always_comb begin
    if (pipe_r[NW].dz) begin
      r_fin = '0;
    end else if (pipe_r[NW].op == OP_DIV) begin
      r_fin = q_fin;
    end else begin
      r_fin = pipe_r[NW].res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= NW; k++) begin
        pipe_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      s0_valid_r <= in_tvalid;
      s0_op_r    <= alu_op_t'(in_tuser);
      s0_a_r     <= DW'($signed(in_tdata[31:0]));
      s0_b_r     <= DW'($signed(in_tdata[63:32]));
      prod_r     <= (2*DW)'(s0_a_r) * (2*DW)'(s0_b_r);
      for (int k = 0; k <= NW; k++) begin
        pipe_r[k] <= pipe_nxt[k];
      end
      out_valid_r <= pipe_r[NW].valid;
      out_data_r  <= FIELD_WIDTH'($signed(r_fin));
      out_user_r  <= {pipe_r[NW].dz, pipe_r[NW].cmp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
